// ----- rtl/dllm_pkg.sv -----
`default_nettype none

package dllm_pkg;

  // fixed field widths of the request and result transactions
  localparam int FUNC_W   = 3;
  localparam int DATA_W   = 32;
  localparam int HANDLE_W = 6;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 7;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;

  localparam int DEF_NODES = 64;

  // request codes
  localparam logic [FUNC_W-1:0] FN_INS_FIRST = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INS_LAST  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_DEL_FIRST = 3'd2;
  localparam logic [FUNC_W-1:0] FN_DEL_LAST  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_INS_AFTER = 3'd4;
  localparam logic [FUNC_W-1:0] FN_DEL_AT    = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADHDL = 2'd3;

  typedef struct packed {
    logic signed [DATA_W-1:0] removed_value;
    logic [HANDLE_W-1:0]      new_node;
    logic [STATUS_W-1:0]      status;
    logic [LEN_W-1:0]         length;
  } dllm_res_t;

endpackage

`default_nettype wire

// ----- rtl/doubly_linked_list_manager_top.sv -----
`default_nettype none

// Doubly linked list in a fixed pool of NODES nodes. Each request transaction
// inserts a word at the front, at the back or after a node handle, or removes
// the front node, the back node or a given handle, and gives exactly one result
// transaction (removed word or new handle, status, list length after the
// request). Node data, forward links, backward links, the in-use flags and the
// free-handle stack live in five single-port synchronous memories with
// registered reads; a small sequencer reads them at acceptance, then writes
// back. A delete or a refused request goes from EXEC back to idle; a
// successful insert also passes through LINK, because the new node and both
// of its neighbors need a write to the link memories and each has one write
// port. A stalled result output holds the result in FIN until it is taken.
// The block takes one request at a time, but a finished result may wait in the
// output register while the next request is accepted. Handles come off a LIFO
// of free nodes; handles never yet handed out are tracked by a low-water mark,
// so no clearing pass is needed after reset and the block is ready at once.
// The null link code is NODES.
module doubly_linked_list_manager_top
  import dllm_pkg::*;
#(
  parameter int NODES = DEF_NODES
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // func [2:0], value [34:3], node [40:35], zero [47:41]
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // removed_value [31:0], new_node [37:32], status [39:38], length [46:40],
  // zero [47]
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;  // handle index width
  localparam int LW = $clog2(NODES + 1);                 // link / count width
  localparam logic [LW-1:0] NULL_LINK = LW'(NODES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LINK,
    S_FIN
  } state_t;

  // request fields
  logic [FUNC_W-1:0]        in_func;
  logic signed [DATA_W-1:0] in_value;
  logic [HANDLE_W-1:0]      in_node;

  assign in_func  = in_tdata[FUNC_W-1:0];
  assign in_value = in_tdata[FUNC_W+DATA_W-1:FUNC_W];
  assign in_node  = in_tdata[FUNC_W+DATA_W+HANDLE_W-1:FUNC_W+DATA_W];

  // control state
  state_t        state_r, state_nxt;
  logic [LW-1:0] head_r, head_nxt;
  logic [LW-1:0] tail_r, tail_nxt;
  logic [LW-1:0] free_top_r, free_top_nxt;
  logic [LW-1:0] low_mark_r, low_mark_nxt;  // lowest stack depth ever reached
  logic [LW-1:0] count_r, count_nxt;
  logic          out_tvalid_r, out_tvalid_nxt;
  dllm_res_t     out_res_r, out_res_nxt;

  // request held while it executes
  logic [FUNC_W-1:0]        func_r;
  logic signed [DATA_W-1:0] value_r;
  logic                     node_ok_r;   // in range and handed out at least once
  logic [IW-1:0]            tgt_r;       // node that was read
  logic [IW-1:0]            pos_r;       // stack slot of the next free handle
  logic                     fresh_r;     // that slot was never written

  // new node held from EXEC to the write-back of its neighbors in LINK
  logic [IW-1:0] ins_h_r, ins_h_nxt;
  logic [LW-1:0] ins_p_r, ins_p_nxt;
  logic [LW-1:0] ins_n_r, ins_n_nxt;
  dllm_res_t     res_r, res_nxt;

  // memories
  logic signed [DATA_W-1:0] val_mem   [NODES];
  logic [LW-1:0]            next_mem  [NODES];
  logic [LW-1:0]            prev_mem  [NODES];
  logic                     inuse_mem [NODES];
  logic [IW-1:0]            stack_mem [NODES];

  logic signed [DATA_W-1:0] rd_val_r;
  logic [LW-1:0]            rd_next_r;
  logic [LW-1:0]            rd_prev_r;
  logic                     rd_inuse_r;
  logic [IW-1:0]            rd_stack_r;

  logic                     val_we, next_we, prev_we, inuse_we, stack_we;
  logic [IW-1:0]            val_wa, next_wa, prev_wa, inuse_wa, stack_wa;
  logic signed [DATA_W-1:0] val_wd;
  logic [LW-1:0]            next_wd, prev_wd;
  logic                     inuse_wd;
  logic [IW-1:0]            stack_wd;

  logic          in_accept;
  logic [IW-1:0] rd_tgt_addr;
  logic [IW-1:0] rd_pos;
  logic [LW-1:0] top_dec;
  logic          out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign in_accept  = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign top_dec    = free_top_r - LW'(1);
  assign rd_pos     = IW'(top_dec);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {1'b0, out_res_r.length, out_res_r.status,
                       out_res_r.new_node, out_res_r.removed_value};

  // delete first/last read the current head/tail, the rest read the given handle
  always_comb begin
    case (in_func)
      FN_DEL_FIRST: rd_tgt_addr = head_r[IW-1:0];
      FN_DEL_LAST:  rd_tgt_addr = tail_r[IW-1:0];
      default:      rd_tgt_addr = IW'(in_node);
    endcase
  end

  // memory ports: one read at acceptance, one write per cycle each
  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[val_wa] <= val_wd;
    end
    if (in_accept) begin
      rd_val_r <= val_mem[rd_tgt_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (in_accept) begin
      rd_next_r <= next_mem[rd_tgt_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    if (in_accept) begin
      rd_prev_r <= prev_mem[rd_tgt_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (inuse_we) begin
      inuse_mem[inuse_wa] <= inuse_wd;
    end
    if (in_accept) begin
      rd_inuse_r <= inuse_mem[IW'(in_node)];
    end
  end

  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack_mem[stack_wa] <= stack_wd;
    end
    if (in_accept) begin
      rd_stack_r <= stack_mem[rd_pos];
    end
  end

  // request capture, no reset needed
  always_ff @(posedge clk) begin
    if (in_accept) begin
      func_r    <= in_func;
      value_r   <= in_value;
      node_ok_r <= (32'(in_node) < NODES) && (32'(in_node) >= 32'(low_mark_r));
      tgt_r     <= rd_tgt_addr;
      pos_r     <= rd_pos;
      fresh_r   <= (top_dec < low_mark_r);
    end
    ins_h_r <= ins_h_nxt;
    ins_p_r <= ins_p_nxt;
    ins_n_r <= ins_n_nxt;
    res_r   <= res_nxt;
  end

  // sequencer
  always_comb begin
    logic          do_ins;
    logic          do_del;
    logic [LW-1:0] p;
    logic [LW-1:0] n;
    logic [IW-1:0] h;
    logic          load_out;
    dllm_res_t     res_c;

    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    free_top_nxt   = free_top_r;
    low_mark_nxt   = low_mark_r;
    count_nxt      = count_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_res_nxt    = out_res_r;
    ins_h_nxt      = ins_h_r;
    ins_p_nxt      = ins_p_r;
    ins_n_nxt      = ins_n_r;
    res_nxt        = res_r;

    val_we   = 1'b0;  val_wa   = '0;  val_wd   = '0;
    next_we  = 1'b0;  next_wa  = '0;  next_wd  = '0;
    prev_we  = 1'b0;  prev_wa  = '0;  prev_wd  = '0;
    inuse_we = 1'b0;  inuse_wa = '0;  inuse_wd = 1'b0;
    stack_we = 1'b0;  stack_wa = '0;  stack_wd = '0;

    do_ins   = 1'b0;
    do_del   = 1'b0;
    p        = NULL_LINK;
    n        = NULL_LINK;
    h        = fresh_r ? pos_r : rd_stack_r;
    load_out = 1'b0;
    res_c    = '0;
    res_c.status = ST_OK;
    res_c.length = LEN_W'(count_r);

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        case (func_r)
          FN_INS_FIRST: begin
            if (free_top_r == '0) begin
              res_c.status = ST_FULL;
            end else begin
              do_ins = 1'b1;
              p      = NULL_LINK;
              n      = head_r;
            end
          end
          FN_INS_LAST: begin
            if (free_top_r == '0) begin
              res_c.status = ST_FULL;
            end else begin
              do_ins = 1'b1;
              p      = tail_r;
              n      = NULL_LINK;
            end
          end
          FN_DEL_FIRST, FN_DEL_LAST: begin
            if (count_r == '0) begin
              res_c.status = ST_EMPTY;
            end else begin
              do_del = 1'b1;
            end
          end
          FN_INS_AFTER: begin
            if (!(node_ok_r && rd_inuse_r)) begin
              res_c.status = ST_BADHDL;
            end else if (free_top_r == '0) begin
              res_c.status = ST_FULL;
            end else begin
              do_ins = 1'b1;
              p      = LW'(tgt_r);
              n      = rd_next_r;
            end
          end
          FN_DEL_AT: begin
            if (!(node_ok_r && rd_inuse_r)) begin
              res_c.status = ST_BADHDL;
            end else begin
              do_del = 1'b1;
            end
          end
          default: begin
          end
        endcase

        if (do_ins) begin
          // new node written whole, neighbors follow in S_LINK
          val_we   = 1'b1;  val_wa   = h;  val_wd   = value_r;
          prev_we  = 1'b1;  prev_wa  = h;  prev_wd  = p;
          next_we  = 1'b1;  next_wa  = h;  next_wd  = n;
          inuse_we = 1'b1;  inuse_wa = h;  inuse_wd = 1'b1;
          free_top_nxt = top_dec;
          if (top_dec < low_mark_r) begin
            low_mark_nxt = top_dec;
          end
          count_nxt = count_r + LW'(1);
          if (p == NULL_LINK) begin
            head_nxt = LW'(h);
          end
          if (n == NULL_LINK) begin
            tail_nxt = LW'(h);
          end
          res_c.new_node = HANDLE_W'(h);
          res_c.length   = LEN_W'(count_r + LW'(1));
          ins_h_nxt = h;
          ins_p_nxt = p;
          ins_n_nxt = n;
          res_nxt   = res_c;
          state_nxt = S_LINK;
        end else begin
          if (do_del) begin
            // bridge the neighbors and push the handle back
            if (rd_prev_r != NULL_LINK) begin
              next_we = 1'b1;
              next_wa = rd_prev_r[IW-1:0];
              next_wd = rd_next_r;
            end else begin
              head_nxt = rd_next_r;
            end
            if (rd_next_r != NULL_LINK) begin
              prev_we = 1'b1;
              prev_wa = rd_next_r[IW-1:0];
              prev_wd = rd_prev_r;
            end else begin
              tail_nxt = rd_prev_r;
            end
            inuse_we = 1'b1;  inuse_wa = tgt_r;  inuse_wd = 1'b0;
            stack_we = 1'b1;  stack_wa = IW'(free_top_r);  stack_wd = tgt_r;
            free_top_nxt = free_top_r + LW'(1);
            count_nxt    = count_r - LW'(1);
            res_c.removed_value = rd_val_r;
            res_c.length        = LEN_W'(count_r - LW'(1));
          end
          res_nxt = res_c;
          if (out_free) begin
            load_out  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end

      S_LINK: begin
        if (ins_p_r != NULL_LINK) begin
          next_we = 1'b1;
          next_wa = ins_p_r[IW-1:0];
          next_wd = LW'(ins_h_r);
        end
        if (ins_n_r != NULL_LINK) begin
          prev_we = 1'b1;
          prev_wa = ins_n_r[IW-1:0];
          prev_wd = LW'(ins_h_r);
        end
        res_c = res_r;
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        res_c = res_r;
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (load_out) begin
      out_tvalid_nxt = 1'b1;
      out_res_nxt    = res_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r       <= NULL_LINK;
      tail_r       <= NULL_LINK;
      free_top_r   <= LW'(NODES);
      low_mark_r   <= LW'(NODES);
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      free_top_r   <= free_top_nxt;
      low_mark_r   <= low_mark_nxt;
      count_r      <= count_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    out_res_r <= out_res_nxt;
  end

endmodule

`default_nettype wire
